@@ rtl/core/btdd_pkg.sv @@
// btdd_pkg: shared constants and types for the binary to decimal digit converter.
// Holds the digit cell control group and the controller state encoding.
// No dependencies.
package btdd_pkg;

   localparam int MAX_DIGITS = 10;
   localparam int VALUE_W    = 32;
   localparam int DIGIT_W    = 4;
   localparam int BIT_CNT_W  = $clog2(VALUE_W);
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

   localparam logic [BIT_CNT_W-1:0] LAST_BIT  = BIT_CNT_W'(VALUE_W - 1);
   localparam logic [CNT_W-1:0]     ALL_SLOTS = CNT_W'(MAX_DIGITS);
   localparam logic [CNT_W-1:0]     ONE_SLOT  = CNT_W'(1);

   typedef struct packed {
      logic clear;
      logic convert;
      logic advance;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

@@ rtl/core/btdd_cell.sv @@
// btdd_cell: one decimal digit cell of the conversion row.
// Does the add-3 and shift step, or takes the digit of the cell below.
// Depends on btdd_pkg.
module btdd_cell
   import btdd_pkg::*;
(
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic               lower_bit,
   input  logic [DIGIT_W-1:0] lower_digit,
   output logic               carry_bit,
   output logic [DIGIT_W-1:0] digit
);

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] adj;

   assign adj = (digit_ff >= DIGIT_W'(5)) ? digit_ff + DIGIT_W'(3) : digit_ff;

   always_comb begin
      digit_in = digit_ff;
      priority if (ctl.clear) begin
         digit_in = '0;
      end else if (ctl.convert) begin
         digit_in = {adj[DIGIT_W-2:0], lower_bit};
      end else if (ctl.advance) begin
         digit_in = lower_digit;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign carry_bit = adj[DIGIT_W-1];
   assign digit     = digit_ff;

endmodule

@@ rtl/core/btdd_chain.sv @@
// btdd_chain: binary shift register feeding a row of decimal digit cells.
// Presents the most significant cell's digit; advance moves digits upward.
// Depends on btdd_pkg and btdd_cell.
module btdd_chain
   import btdd_pkg::*;
(
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [VALUE_W-1:0] value,
   output logic [DIGIT_W-1:0] top_digit,
   output logic               overflow
);

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;
   logic               carry [MAX_DIGITS+1];
   logic [DIGIT_W-1:0] dig   [MAX_DIGITS+1];

   always_comb begin
      value_in = value_ff;
      priority if (ctl.clear) begin
         value_in = value;
      end else if (ctl.convert) begin
         value_in = {value_ff[VALUE_W-2:0], 1'b0};
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign carry[0] = value_ff[VALUE_W-1];
   assign dig[0]   = '0;

   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      btdd_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .lower_bit   (carry[i]),
         .lower_digit (dig[i]),
         .carry_bit   (carry[i+1]),
         .digit       (dig[i+1])
      );
   end

   assign top_digit = dig[MAX_DIGITS];
   assign overflow  = carry[MAX_DIGITS];

endmodule

@@ rtl/core/binary_to_decimal_digits.sv @@
// binary_to_decimal_digits: top level of the binary to decimal digit converter.
// Sequences conversion and digit emission over the row of cells.
// Depends on btdd_pkg and btdd_chain.
//
//   channel  direction  tdata (low bit up)      tlast
//   req      in         value[31:0]             -
//   rsp      out        digit[3:0], zero pad    last digit of the run
//
// One item is accepted, then converted through the cell row one value bit at a time;
// then each of the ten digit slots in turn is dropped as a suppressed leading zero
// or emitted. The last slot is always emitted, so a zero value gives one digit.
// A new item is accepted while the final digit of the previous one waits.
// Reset clears the controller and the output valid; the cell row needs none.
// A stalled rsp holds the digit in the output register and freezes the row
// at the next digit to emit; leading zeros are dropped regardless.
module binary_to_decimal_digits
   import btdd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // value[31:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // digit[3:0], zeros[7:4]
   output logic         rsp_tlast
);

   state_type              state_ff, state_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0]       remain_ff, remain_in;
   logic                   started_ff, started_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_W-1:0]     rsp_digit_ff, rsp_digit_in;
   logic                   rsp_last_ff, rsp_last_in;
   cell_ctl_type           ctl;
   logic [DIGIT_W-1:0]     top_digit;
   logic                   overflow;
   logic                   skip;
   logic                   slot_free;
   logic                   is_last;

   btdd_chain u_chain (
      .clock     (clock),
      .ctl       (ctl),
      .value     (req_tdata),
      .top_digit (top_digit),
      .overflow  (overflow)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign is_last    = (remain_ff == ONE_SLOT);
   assign skip       = !started_ff && (top_digit == '0) && !is_last && !overflow;

   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      remain_in    = remain_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_digit_in = rsp_digit_ff;
      rsp_last_in  = rsp_last_ff;
      ctl          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctl.clear  = 1'b1;
               bit_cnt_in = '0;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            ctl.convert = 1'b1;
            bit_cnt_in  = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == LAST_BIT) begin
               remain_in  = ALL_SLOTS;
               started_in = 1'b0;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (skip) begin
               ctl.advance = 1'b1;
               remain_in   = remain_ff - ONE_SLOT;
            end else if (slot_free) begin
               ctl.advance  = 1'b1;
               remain_in    = remain_ff - ONE_SLOT;
               started_in   = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_digit_in = top_digit;
               rsp_last_in  = is_last;
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         started_ff   <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_cnt_ff   <= bit_cnt_in;
      remain_ff    <= remain_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_digit_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for binary_to_decimal_digits on its req and rsp streams.
// Predicts the digit run of every accepted value and checks each rsp item in order.
// Depends on btdd_pkg and binary_to_decimal_digits.
`timescale 1ns / 100ps

module tb;
   import btdd_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_STRETCH = 400;

   typedef struct {
      logic [3:0] digit;
      logic       last;
   } digit_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   digit_entry_type pending_digits[$];
   digit_entry_type want;
   int unsigned     cycle_count = 0;
   int unsigned     error_count = 0;
   int unsigned     send_idle_pct = 0;
   int unsigned     recv_idle_pct = 0;
   int unsigned     hold_cycles = 0;
   logic            rsp_hold = 1'b0;

   binary_to_decimal_digits uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   task automatic flag_error(input string msg);
      $display("error at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic void split_into_digits(input logic [31:0] value);
      logic [3:0]  dig [MAX_DIGITS];
      logic [31:0] rest;
      int          top;
      rest = value;
      top = 1;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         dig[i] = 4'(rest % 32'd10);
         rest = rest / 32'd10;
         if (dig[i] != 4'd0)
            top = i + 1;
      end
      for (int i = top - 1; i >= 0; i--)
         pending_digits.push_back('{digit: dig[i], last: (i == 0)});
   endfunction

   // offer one item, with an optional gap first; valid stays high afterwards
   task automatic send_value(input logic [31:0] value);
      int unsigned gap;
      gap = 0;
      if (send_idle_pct != 0) begin
         while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
         if ($urandom_range(0, 19) == 0)
            gap += $urandom_range(1, 60);
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         req_tdata <= $urandom();
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      split_into_digits(value);
   endtask

   always @(posedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // hold off the receiver for a counted stretch
   initial begin
      forever begin
         wait (hold_cycles != 0);
         rsp_hold <= 1'b1;
         repeat (hold_cycles) @(posedge clock);
         rsp_hold <= 1'b0;
         hold_cycles = 0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_digits.size() == 0) begin
            flag_error($sformatf("unexpected item, tdata %h tlast %b", rsp_tdata, rsp_tlast));
         end else begin
            want = pending_digits.pop_front();
            if (rsp_tdata !== {4'b0000, want.digit})
               flag_error($sformatf("digit: expected %0d, got tdata %h",
                                    want.digit, rsp_tdata));
            if (rsp_tlast !== want.last)
               flag_error($sformatf("last: expected %b, got %b", want.last, rsp_tlast));
         end
      end
   end

   task automatic test_directed();
      logic [31:0] corner [$];
      corner = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101,
                 32'd5763161, 32'd100200300, 32'd999999999, 32'd1000000000,
                 32'd1000000001, 32'd2147483647, 32'd2147483648, 32'd4000000000,
                 32'd4294967295, 32'd4294967290, 32'd3000000005, 32'd1234567890,
                 32'd90, 32'd7, 32'hAAAAAAAA, 32'h55555555, 32'd0};
      foreach (corner[i])
         send_value(corner[i]);
   endtask

   task automatic test_random(input int unsigned count);
      logic [31:0]     value;
      int unsigned     span;
      longint unsigned acc;
      int unsigned     n;
      repeat (count) begin
         case ($urandom_range(0, 3))
            0: value = $urandom();
            1: begin
               n = $urandom_range(1, 9);
               span = 1;
               repeat (n) span *= 10;
               value = $urandom_range(span - 1, 0);
            end
            2: begin
               // digit strings rich in zeros
               n = $urandom_range(1, 10);
               acc = 0;
               repeat (n)
                  acc = acc * 10 + (($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 9));
               value = acc[31:0];
            end
            default: value = $urandom_range(0, 99);
         endcase
         send_value(value);
      end
   endtask

   // fill the block while the receiver is held off
   task automatic test_output_stall();
      hold_cycles = HOLD_STRETCH;
      repeat (10)
         send_value($urandom());
   endtask

   // drain fully, then resume
   task automatic test_drain_pause();
      repeat (4)
         send_value($urandom());
      req_tvalid <= 1'b0;
      while (pending_digits.size() != 0)
         @(posedge clock);
      repeat (4)
         send_value($urandom_range(0, 999));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 28;
      recv_idle_pct = 50;
      test_directed();
      test_random(140);
      test_output_stall();

      send_idle_pct = 50;
      recv_idle_pct = 28;
      test_random(140);
      test_drain_pause();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(140);

      req_tvalid <= 1'b0;
      while (pending_digits.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
